/* sv/ddpt_pkg.sv */
package ddpt_pkg;

  // fixed-point formats
  localparam int HF = 24;                  // heading fraction bits
  localparam int PF = 16;                  // position fraction bits
  localparam int GF = 24;                  // gain fraction bits
  localparam int HW = HF + 2;              // heading width
  localparam int MS = GF + HF - PF;        // shift from product scale to position scale
  localparam int VW = GF + HF + 4;         // turn / move vector width
  localparam int NT = 30;                  // normalized magnitude lies in [2^(NT-1), 2^NT)
  localparam int SQW = 2 * NT + 1;         // sum of squares width
  localparam int NB = NT + 1;              // root width
  localparam int QB = HF + 1;              // quotient bits
  localparam int NUMW = NT + HF + 1;       // dividend width
  localparam int DW = NB + 1;              // partial remainder width
  localparam int CNTW = 5;
  localparam int VEC_STEPS = 5;
  localparam int SQ_STEPS = (SQW + 1) / 2;

  localparam logic [23:0] STEP_RST = 24'd3118465;
  localparam logic [23:0] FWD_RST  = 24'd1559200;
  localparam logic [23:0] LAT_RST  = 24'd8677;

  typedef enum logic [1:0] {
    CFG_STEP = 2'd0,
    CFG_FWD  = 2'd1,
    CFG_LAT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEC,
    ST_MOVE,
    ST_ABS,
    ST_SHIFT,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_DIVX_LD,
    ST_DIVX,
    ST_DIVY_LD,
    ST_DIVY,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_AX,
    MUL_BX,
    MUL_AY,
    MUL_BY
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_LOAD_X,
    ACC_ADD_X,
    ACC_LOAD_Y,
    ACC_ADD_Y
  } acc_op_t;

  typedef struct packed {
    logic     straight;
    logic     ccw;
    logic     backward;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     move_en;
    logic     abs_en;
    logic     shift_en;
    logic     sqx_en;
    logic     sqy_en;
    logic     sqrt_en;
    logic     div_load;
    logic     div_en;
    logic     div_write;
    logic     div_y;
  } dp_cmd_t;

  typedef struct packed {
    logic vzero;
    logic mag_hi;
    logic mag_lo;
  } dp_sts_t;

endpackage

/* sv/ddpt_ctrl.sv */
module ddpt_ctrl
  import ddpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] left_raw,
  input  logic [1:0] right_raw,
  input  logic       out_free,
  input  dp_sts_t    sts,
  output logic       in_ready,
  output logic       out_load,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic straight_r, ccw_r, bwd_r, move_r, turn_r;
  logic straight_nxt, ccw_nxt, bwd_nxt, move_nxt, turn_nxt;
  logic lz, lp, ln, rz, rp, rn, deq, spin, pivot, none, accept;

  // wheel decode: any negative code counts as backward
  always_comb begin
    lz = (left_raw == 2'b00);
    lp = (left_raw == 2'b01);
    ln = left_raw[1];
    rz = (right_raw == 2'b00);
    rp = (right_raw == 2'b01);
    rn = right_raw[1];
    deq = (lz && rz) || (lp && rp) || (ln && rn);
    none = lz && rz;
    spin = !deq && !lz && !rz;
    pivot = !deq && (lz || rz);
    accept = in_valid && in_ready;
  end

  always_comb begin
    straight_nxt = straight_r;
    ccw_nxt = ccw_r;
    bwd_nxt = bwd_r;
    move_nxt = move_r;
    turn_nxt = turn_r;
    if (accept) begin
      straight_nxt = deq && !lz;
      ccw_nxt = spin ? rp : (lz ? rp : ln);
      bwd_nxt = (deq && !lz) ? ln : (lz ? !rp : !lp);
      move_nxt = (deq && !lz) || pivot;
      turn_nxt = spin || pivot;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = none ? ST_DONE : ST_VEC;
      end
      ST_VEC: begin
        if (cnt_r == CNTW'(VEC_STEPS - 1)) state_nxt = move_r ? ST_MOVE : ST_ABS;
      end
      ST_MOVE:    state_nxt = turn_r ? ST_ABS : ST_DONE;
      ST_ABS:     state_nxt = ST_SHIFT;
      ST_SHIFT: begin
        if (sts.vzero) state_nxt = ST_DONE;
        else if (!sts.mag_hi && !sts.mag_lo) state_nxt = ST_SQX;
      end
      ST_SQX:     state_nxt = ST_SQY;
      ST_SQY:     state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (cnt_r == CNTW'(SQ_STEPS - 1)) state_nxt = ST_DIVX_LD;
      end
      ST_DIVX_LD: state_nxt = ST_DIVX;
      ST_DIVX: begin
        if (cnt_r == CNTW'(QB - 1)) state_nxt = ST_DIVY_LD;
      end
      ST_DIVY_LD: state_nxt = ST_DIVY;
      ST_DIVY: begin
        if (cnt_r == CNTW'(QB - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  assign cnt_nxt = (state_nxt != state_r) ? '0 : cnt_r + 1'b1;

  // outputs
  always_comb begin
    cmd = '0;
    cmd.straight = straight_r;
    cmd.ccw = ccw_r;
    cmd.backward = bwd_r;
    cmd.mul_sel = MUL_AX;
    cmd.acc_op = ACC_NONE;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_VEC: begin
        case (cnt_r)
          CNTW'(0): cmd.mul_sel = MUL_AX;
          CNTW'(1): begin
            cmd.mul_sel = MUL_BX;
            cmd.acc_op = ACC_LOAD_X;
          end
          CNTW'(2): begin
            cmd.mul_sel = MUL_AY;
            cmd.acc_op = ACC_ADD_X;
          end
          CNTW'(3): begin
            cmd.mul_sel = MUL_BY;
            cmd.acc_op = ACC_LOAD_Y;
          end
          default: cmd.acc_op = ACC_ADD_Y;
        endcase
      end
      ST_MOVE:    cmd.move_en = 1'b1;
      ST_ABS:     cmd.abs_en = 1'b1;
      ST_SHIFT:   cmd.shift_en = 1'b1;
      ST_SQX:     cmd.sqx_en = 1'b1;
      ST_SQY:     cmd.sqy_en = 1'b1;
      ST_SQRT:    cmd.sqrt_en = 1'b1;
      ST_DIVX_LD: cmd.div_load = 1'b1;
      ST_DIVX: begin
        cmd.div_en = 1'b1;
        cmd.div_write = (cnt_r == CNTW'(QB - 1));
      end
      ST_DIVY_LD: begin
        cmd.div_load = 1'b1;
        cmd.div_y = 1'b1;
      end
      ST_DIVY: begin
        cmd.div_en = 1'b1;
        cmd.div_y = 1'b1;
        cmd.div_write = (cnt_r == CNTW'(QB - 1));
      end
      ST_DONE:    out_load = out_free;
      default:    in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      straight_r <= 1'b0;
      ccw_r <= 1'b0;
      bwd_r <= 1'b0;
      move_r <= 1'b0;
      turn_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      straight_r <= straight_nxt;
      ccw_r <= ccw_nxt;
      bwd_r <= bwd_nxt;
      move_r <= move_nxt;
      turn_r <= turn_nxt;
    end
  end

endmodule

/* sv/ddpt_dp.sv */
module ddpt_dp
  import ddpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  logic [23:0]           step_len,
  input  logic [23:0]           fwd_gain,
  input  logic [23:0]           lat_gain,
  output dp_sts_t               sts,
  output logic signed [31:0]    pos_x,
  output logic signed [31:0]    pos_y,
  output logic signed [HW-1:0]  hd_x,
  output logic signed [HW-1:0]  hd_y,
  output logic signed [15:0]    coarse_x,
  output logic signed [15:0]    coarse_y
);

  localparam logic signed [VW:0] MOVE_RND = (VW + 1)'(1) <<< (MS - 1);

  logic signed [31:0]   pos_x_r, pos_y_r;
  logic signed [HW-1:0] hd_x_r, hd_y_r;
  logic signed [VW-1:0] prod_r, vx_r, vy_r;
  logic [VW-1:0]        ax_r, ay_r;
  logic [2*NT-1:0]      sq_r;
  logic [SQW-1:0]       rem_r, root_r, bit_r;
  logic [DW-1:0]        drem_r;
  logic [QB-1:0]        nlo_r, quo_r;

  logic [GF-1:0]        gain;
  logic signed [HW:0]   opnd;
  logic signed [VW-1:0] prod;
  logic signed [VW:0]   rx, ry, dxf, dyf;
  logic signed [33:0]   sx, sy;
  logic [VW-1:0]        mag_or;
  logic [2*NT-1:0]      sq_y;
  logic [SQW:0]         sq_t;
  logic                 sq_ge;
  logic [NB-1:0]        nroot;
  logic [NT-1:0]        div_a;
  logic [NUMW-1:0]      num_full;
  logic [DW-1:0]        trial;
  logic                 qbit;
  logic [QB-1:0]        q;
  logic signed [HW-1:0] hd_new;
  logic                 vneg;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] s);
    logic signed [31:0] res;
    if (s[33:31] == 3'b000 || s[33:31] == 3'b111) res = s[31:0];
    else if (s[33]) res = 32'sh8000_0000;
    else res = 32'sh7fff_ffff;
    return res;
  endfunction

  // round to whole units, saturate, then halve toward zero
  function automatic logic signed [15:0] coarse(input logic signed [31:0] p);
    logic signed [32:0] s;
    logic signed [32:0] t;
    logic signed [16:0] c;
    s = {p[31], p} + 33'sd32768;
    t = s[32] ? ((s + 33'sd65535) >>> PF) : (s >>> PF);
    if (t > 33'sd32767) c = 17'sd32767;
    else if (t < -33'sd32768) c = -17'sd32768;
    else c = t[16:0];
    c = (c + {16'd0, c[16]}) >>> 1;
    return c[15:0];
  endfunction

  // shared multiplier for turn and move vectors
  always_comb begin
    case (cmd.mul_sel)
      MUL_AX: begin
        gain = cmd.straight ? step_len : fwd_gain;
        opnd = {hd_x_r[HW-1], hd_x_r};
      end
      MUL_AY: begin
        gain = cmd.straight ? step_len : fwd_gain;
        opnd = {hd_y_r[HW-1], hd_y_r};
      end
      MUL_BX: begin
        gain = cmd.straight ? '0 : lat_gain;
        opnd = cmd.ccw ? -{hd_y_r[HW-1], hd_y_r} : {hd_y_r[HW-1], hd_y_r};
      end
      default: begin
        gain = cmd.straight ? '0 : lat_gain;
        opnd = cmd.ccw ? {hd_x_r[HW-1], hd_x_r} : -{hd_x_r[HW-1], hd_x_r};
      end
    endcase
    prod = $signed({1'b0, gain}) * opnd;
  end

  always_comb begin
    rx = {vx_r[VW-1], vx_r} + MOVE_RND;
    ry = {vy_r[VW-1], vy_r} + MOVE_RND;
    dxf = rx >>> MS;
    dyf = ry >>> MS;
    sx = cmd.backward ? ({{2{pos_x_r[31]}}, pos_x_r} - dxf[33:0])
                      : ({{2{pos_x_r[31]}}, pos_x_r} + dxf[33:0]);
    sy = cmd.backward ? ({{2{pos_y_r[31]}}, pos_y_r} - dyf[33:0])
                      : ({{2{pos_y_r[31]}}, pos_y_r} + dyf[33:0]);
  end

  // magnitude window check on the or of both components
  always_comb begin
    mag_or = ax_r | ay_r;
    sts.vzero = (mag_or == '0);
    sts.mag_hi = |mag_or[VW-1:NT];
    sts.mag_lo = !sts.mag_hi && !mag_or[NT-1];
  end

  always_comb begin
    sq_y = ay_r[NT-1:0] * ay_r[NT-1:0];
    sq_t = {1'b0, root_r} + {1'b0, bit_r};
    sq_ge = {1'b0, rem_r} >= sq_t;
    nroot = root_r[NB-1:0];
    div_a = cmd.div_y ? ay_r[NT-1:0] : ax_r[NT-1:0];
    num_full = {1'b0, div_a, {HF{1'b0}}} + NUMW'(nroot >> 1);
    trial = {drem_r[DW-2:0], nlo_r[QB-1]};
    qbit = trial >= {1'b0, nroot};
    q = {quo_r[QB-2:0], qbit};
    vneg = cmd.div_y ? vy_r[VW-1] : vx_r[VW-1];
    hd_new = vneg ? -$signed(HW'(q)) : $signed(HW'(q));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      hd_x_r <= '0;
      hd_y_r <= HW'(1) <<< HF;
    end else begin
      if (cmd.move_en) begin
        pos_x_r <= sat32(sx);
        pos_y_r <= sat32(sy);
      end
      if (cmd.div_write) begin
        if (cmd.div_y) hd_y_r <= hd_new;
        else hd_x_r <= hd_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod;
    case (cmd.acc_op)
      ACC_LOAD_X: vx_r <= prod_r;
      ACC_ADD_X:  vx_r <= vx_r + prod_r;
      ACC_LOAD_Y: vy_r <= prod_r;
      ACC_ADD_Y:  vy_r <= vy_r + prod_r;
      default:    vx_r <= vx_r;
    endcase
    if (cmd.abs_en) begin
      ax_r <= vx_r[VW-1] ? VW'(-vx_r) : VW'(vx_r);
      ay_r <= vy_r[VW-1] ? VW'(-vy_r) : VW'(vy_r);
    end else if (cmd.shift_en && sts.mag_hi) begin
      ax_r <= ax_r >> 1;
      ay_r <= ay_r >> 1;
    end else if (cmd.shift_en && sts.mag_lo && !sts.vzero) begin
      ax_r <= ax_r << 1;
      ay_r <= ay_r << 1;
    end
    if (cmd.sqx_en) sq_r <= ax_r[NT-1:0] * ax_r[NT-1:0];
    if (cmd.sqy_en) begin
      rem_r <= SQW'(sq_r) + SQW'(sq_y);
      root_r <= '0;
      bit_r <= SQW'(1) << (2 * (SQ_STEPS - 1));
    end else if (cmd.sqrt_en) begin
      if (sq_ge) begin
        rem_r <= rem_r - sq_t[SQW-1:0];
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.div_load) begin
      drem_r <= DW'(num_full[NUMW-1:QB]);
      nlo_r <= num_full[QB-1:0];
      quo_r <= '0;
    end else if (cmd.div_en) begin
      drem_r <= qbit ? (trial - {1'b0, nroot}) : trial;
      nlo_r <= nlo_r << 1;
      quo_r <= q;
    end
  end

  assign pos_x = pos_x_r;
  assign pos_y = pos_y_r;
  assign hd_x = hd_x_r;
  assign hd_y = hd_y_r;
  assign coarse_x = coarse(pos_x_r);
  assign coarse_y = coarse(pos_y_r);

endmodule

/* sv/diff_drive_pose_tracker.sv */
// channel | dir | handshake                 | payload
// in_     | in  | in_tvalid / in_tready     | in_tdata: left_drive, right_drive
// out_    | out | out_tvalid / out_tready   | out_tdata: pose and coarse position
// cfg_    | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data
// one request at a time: both wheels still goes straight to the result, a straight move
// runs the vector multiply and a position update, a turn the vector multiply, one-bit-per-cycle
// normalizing shift, 31-step square root and two 25-step divisions through one shared divider
// reset restores gains, clears position and points the heading along +y
// a finished result sits in the output register; the next request is taken
// while it waits, and completion stalls only until the register frees
module diff_drive_pose_tracker
  import ddpt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [1:0] left_drive, [3:2] right_drive
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] pos_x, [63:32] pos_y, [89:64] head_x, [115:90] head_y,
  // [131:116] coarse_x, [147:132] coarse_y
  output logic [151:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  logic [23:0] step_r, fwd_r, lat_r;
  logic        out_valid_r, out_valid_nxt;
  logic [151:0] out_data_r;
  logic        out_load, out_free;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic signed [31:0]   pos_x, pos_y;
  logic signed [HW-1:0] hd_x, hd_y;
  logic signed [15:0]   coarse_x, coarse_y;

  assign cfg_ready = 1'b1;
  assign out_free = !out_valid_r || out_tready;

  ddpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .left_raw (in_tdata[1:0]),
    .right_raw(in_tdata[3:2]),
    .out_free (out_free),
    .sts      (sts),
    .in_ready (in_tready),
    .out_load (out_load),
    .cmd      (cmd)
  );

  ddpt_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .step_len (step_r),
    .fwd_gain (fwd_r),
    .lat_gain (lat_r),
    .sts      (sts),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .hd_x     (hd_x),
    .hd_y     (hd_y),
    .coarse_x (coarse_x),
    .coarse_y (coarse_y)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RST;
      fwd_r <= FWD_RST;
      lat_r <= LAT_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STEP: step_r <= cfg_data;
          CFG_FWD:  fwd_r <= cfg_data;
          CFG_LAT:  lat_r <= cfg_data;
          default:  step_r <= step_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= {4'b0000, coarse_y, coarse_x, hd_y, hd_x, pos_y, pos_x};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  // a request is taken only from idle, so ready drops right after it
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // the heading stays a unit vector, never both components zero
  a_heading_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[89:64] != 26'd0 || out_tdata[115:90] != 26'd0))
    else $error("heading collapsed to zero");

  // a result is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("result overwritten");

endmodule
